>>> rtl/core/ils_pkg.sv
// Shared types and codes for the indexed list store.
`timescale 1ns / 1ps

package ils_pkg;

   localparam int OP_WIDTH     = 3;
   localparam int POS_WIDTH    = 5;
   localparam int DATA_WIDTH   = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 5;

   // Command codes carried in the operation field.
   localparam logic [OP_WIDTH-1:0] OP_ADD_FRONT    = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_ADD_REAR     = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_REMOVE_FRONT = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_REMOVE_REAR  = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_INSERT_AT    = 3'd4;
   localparam logic [OP_WIDTH-1:0] OP_DELETE_AT    = 3'd5;

   // Result status codes.
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_RANGE     = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL      = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the incoming item
      logic execute;   // apply the latched command to the list
   } dp_cmd_type;

endpackage

>>> rtl/core/ils_controller.sv
// Sequencing state machine for the indexed list store.
`timescale 1ns / 1ps

module ils_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output ils_pkg::dp_cmd_type dp_cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SEND
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && ready_ff) begin
                  state_ff <= ST_EXEC;
                  ready_ff <= 1'b0;
               end else begin
                  ready_ff <= 1'b1;
               end
            end
            ST_EXEC: begin
               state_ff <= ST_SEND;
               valid_ff <= 1'b1;
            end
            ST_SEND: begin
               if (rsp_tready) begin
                  state_ff <= ST_IDLE;
                  valid_ff <= 1'b0;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b0;
               valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_tready     = ready_ff;
   assign rsp_tvalid     = valid_ff;
   assign dp_cmd.capture = req_tvalid && ready_ff;
   assign dp_cmd.execute = (state_ff == ST_EXEC);

`ifndef SYNTH
   // Only one item is in flight: no new item while a result is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ready_ff && valid_ff))
      else $error("input ready while a result is pending");
`endif

endmodule

>>> rtl/core/ils_datapath.sv
// Register-cell row holding the list, with its command decode and result registers.
`timescale 1ns / 1ps

module ils_datapath #(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ils_pkg::dp_cmd_type                 dp_cmd,
   input  logic [ils_pkg::OP_WIDTH-1:0]        operation,
   input  logic [ils_pkg::POS_WIDTH-1:0]       position,
   input  logic signed [ils_pkg::DATA_WIDTH-1:0] value_in,
   output logic signed [ils_pkg::DATA_WIDTH-1:0] removed_value,
   output logic [ils_pkg::STATUS_WIDTH-1:0]    status,
   output logic [ils_pkg::COUNT_WIDTH-1:0]     entry_count,
   output logic                                is_empty
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int IW   = $clog2(CAPACITY);
   localparam int CMPW = ((CW > ils_pkg::POS_WIDTH) ? CW : ils_pkg::POS_WIDTH) + 1;

   logic [VALUE_WIDTH-1:0]                cells_ff [CAPACITY];
   logic [VALUE_WIDTH-1:0]                cells_in [CAPACITY];
   logic [CW-1:0]                         count_ff;
   logic [CW-1:0]                         count_in;
   logic [ils_pkg::OP_WIDTH-1:0]          op_ff;
   logic [ils_pkg::POS_WIDTH-1:0]         pos_ff;
   logic [VALUE_WIDTH-1:0]                value_ff;
   logic signed [ils_pkg::DATA_WIDTH-1:0] removed_ff;
   logic signed [ils_pkg::DATA_WIDTH-1:0] removed_in;
   logic [ils_pkg::STATUS_WIDTH-1:0]      status_ff;
   logic [ils_pkg::STATUS_WIDTH-1:0]      status_in;

   logic [CMPW-1:0] pos_ext;
   logic [CMPW-1:0] cnt_ext;
   logic [CMPW-1:0] pos_minus_one;
   logic            list_full;
   logic            list_empty;
   logic            do_insert;
   logic            do_delete;
   logic [IW-1:0]   ins_idx;
   logic [IW-1:0]   del_idx;

   assign pos_ext       = CMPW'(pos_ff);
   assign cnt_ext       = CMPW'(count_ff);
   assign pos_minus_one = pos_ext - CMPW'(1);
   assign list_full     = (count_ff == CW'(CAPACITY));
   assign list_empty    = (count_ff == '0);

   // Decode the latched command into an insert or a delete at one index.
   always_comb begin
      do_insert = 1'b0;
      do_delete = 1'b0;
      ins_idx   = '0;
      del_idx   = '0;
      status_in = ils_pkg::STATUS_OK;
      unique case (op_ff)
         ils_pkg::OP_ADD_FRONT, ils_pkg::OP_ADD_REAR: begin
            if (list_full) begin
               status_in = ils_pkg::STATUS_FULL;
            end else begin
               do_insert = 1'b1;
               ins_idx   = (op_ff == ils_pkg::OP_ADD_FRONT) ? '0 : IW'(count_ff);
            end
         end
         ils_pkg::OP_REMOVE_FRONT, ils_pkg::OP_REMOVE_REAR: begin
            if (list_empty) begin
               status_in = ils_pkg::STATUS_UNDERFLOW;
            end else begin
               do_delete = 1'b1;
               del_idx   = (op_ff == ils_pkg::OP_REMOVE_FRONT) ? '0 :
                           IW'(count_ff - CW'(1));
            end
         end
         ils_pkg::OP_INSERT_AT: begin
            if (pos_ext == '0 || pos_ext > cnt_ext + CMPW'(1)) begin
               status_in = ils_pkg::STATUS_RANGE;
            end else if (list_full) begin
               status_in = ils_pkg::STATUS_FULL;
            end else begin
               do_insert = 1'b1;
               ins_idx   = IW'(pos_minus_one);
            end
         end
         ils_pkg::OP_DELETE_AT: begin
            if (pos_ext == '0 || pos_ext > cnt_ext) begin
               status_in = ils_pkg::STATUS_RANGE;
            end else begin
               do_delete = 1'b1;
               del_idx   = IW'(pos_minus_one);
            end
         end
         default: begin
            status_in = ils_pkg::STATUS_RANGE;
         end
      endcase
   end

   // Every cell picks its neighbor, the new value, or itself.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
         if (do_insert) begin
            if (IW'(i) == ins_idx) begin
               cells_in[i] = value_ff;
            end else if (i > 0 && IW'(i) > ins_idx) begin
               cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (do_delete) begin
            if (i < CAPACITY - 1 && IW'(i) >= del_idx) begin
               cells_in[i] = cells_ff[(i < CAPACITY - 1) ? i + 1 : i];
            end
         end
      end
   end

   assign removed_in = do_delete ?
                       ils_pkg::DATA_WIDTH'($signed(cells_ff[del_idx])) : '0;

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CW'(1);
      end else if (do_delete) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (dp_cmd.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         op_ff    <= operation;
         pos_ff   <= position;
         value_ff <= VALUE_WIDTH'($signed(value_in));
      end
      if (dp_cmd.execute) begin
         cells_ff   <= cells_in;
         removed_ff <= removed_in;
         status_ff  <= status_in;
      end
   end

   assign removed_value = removed_ff;
   assign status        = status_ff;
   assign entry_count   = ils_pkg::COUNT_WIDTH'(count_ff);
   assign is_empty      = list_empty;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_failed_keeps: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.execute && status_in != ils_pkg::STATUS_OK |=> $stable(count_ff))
      else $error("failed command changed the entry count");

   a_idle_keeps: assert property (@(posedge clock) disable iff (reset)
      !dp_cmd.execute |=> $stable(count_ff))
      else $error("entry count changed outside execution");
`endif

endmodule

>>> rtl/core/indexed_list_store_unit.sv
// Top level of the indexed list store: stream ports, controller and cell row.
`timescale 1ns / 1ps

// The indexed list store keeps an ordered list of up to CAPACITY signed values in a
// row of register cells, front at cell 0. Each request item carries a command in
// req_tuser: add at front or rear, remove from front or rear, insert at a 1-based
// position (1 to count+1), or delete at a 1-based position (1 to count). All later
// entries shift by one cell in the same clock edge to open or close the gap. Every
// request produces exactly one response item holding the removed value (zero unless
// a removal succeeded), the resulting entry count, an empty flag and a status: ok,
// underflow on removal from an empty list, out of range for a bad position or an
// unknown command, and full when an add or a valid insert meets a full list. A
// failed command leaves the list untouched. One item is handled at a time: it is
// latched when the request is accepted, applied to the cell row in the execute state,
// and its response is then offered until rsp_tready takes it; no new request is
// accepted before that. Values are stored in VALUE_WIDTH bits
// and sign extended to 32 bits on removal; the count reported is its low five bits.
module indexed_list_store_unit #(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [4:0] position, [36:5] value_in, [39:37] zero
   input  logic [2:0]  req_tuser,   // [2:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] removed_value, [36:32] entry_count,
                                    // [37] is_empty, [39:38] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   ils_pkg::dp_cmd_type dp_cmd;

   logic signed [ils_pkg::DATA_WIDTH-1:0] removed_value;
   logic [ils_pkg::STATUS_WIDTH-1:0]      status;
   logic [ils_pkg::COUNT_WIDTH-1:0]       entry_count;
   logic                                  is_empty;

   // The controller owns the handshakes and tells the datapath when to latch and when
   // to apply a command.
   ils_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd)
   );

   // The datapath holds the cell row, the entry count and the registered result,
   // which stays stable while the response waits.
   ils_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .dp_cmd        (dp_cmd),
      .operation     (req_tuser),
      .position      (req_tdata[4:0]),
      .value_in      (req_tdata[36:5]),
      .removed_value (removed_value),
      .status        (status),
      .entry_count   (entry_count),
      .is_empty      (is_empty)
   );

   assign rsp_tdata = {2'b00, is_empty, entry_count, removed_value};
   assign rsp_tuser = status;

endmodule
